// ----- rtl/core/hs_pkg.sv -----
// hs_pkg: sizes and sequencer state encoding for the heap sorter
// no dependencies; used by heap_sorter
package hs_pkg;

  localparam int DEPTH = 64;                  // store capacity
  localparam int AW    = $clog2(DEPTH);       // store address width
  localparam int CW    = $clog2(DEPTH + 1);   // count width, holds DEPTH itself
  localparam int LW    = AW + 2;              // child index width (2*root+2)
  localparam int DW    = 32;                  // element width

  typedef enum logic [9:0] {
    S_LOAD   = 10'b00_0000_0001,
    S_FETCH  = 10'b00_0000_0010,
    S_ROOT   = 10'b00_0000_0100,
    S_KIDS   = 10'b00_0000_1000,
    S_CMPL   = 10'b00_0001_0000,
    S_CMPR   = 10'b00_0010_0000,
    S_XFETCH = 10'b00_0100_0000,
    S_XSWAP  = 10'b00_1000_0000,
    S_ERD    = 10'b01_0000_0000,
    S_EOUT   = 10'b10_0000_0000
  } state_t;

endpackage

// ----- rtl/core/heap_sorter.sv -----
// heap_sorter: collects signed values, heapsorts them in place, emits ascending
// depends on hs_pkg

// Values are taken one per cycle into a store of DEPTH entries (in_stall low
// while loading). The transaction marked last is stored (if there is room) and
// starts the sort; values arriving with the store full are discarded and every
// result of that run carries dropped. The sort runs on a single two-read,
// one-write store and one shared signed comparator: each sift-down level
// reads the children, compares the left one, then compares the right one and
// writes; a sift first fetches its root value while the heap is built, and
// reads the root and swaps it with the tail during extraction. The run then
// emits the results in ascending order, each read from the store and held
// until the output can take it. The block is busy after the last transaction,
// with in_stall high, and the final result carries end_of_run. The next set
// can be loaded while the last result still waits in the output register.
module heap_sorter
  import hs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] in_value,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_sorted_value,
  output logic                 out_end_of_run,
  output logic                 out_dropped
);

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rd_a_r, rd_b_r;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [AW-1:0]        root_r, root_nxt;
  logic [AW-1:0]        bigi_r, bigi_nxt;
  logic                 moved_r, moved_nxt;
  logic                 build_r, build_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic signed [DW-1:0] vr_r, vr_nxt;
  logic signed [DW-1:0] best_r, best_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_value_r, out_value_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_drop_r, out_drop_nxt;

  logic                 we_c;
  logic [AW-1:0]        wa_c, ra_c, rb_c;
  logic signed [DW-1:0] wd_c;

  logic [LW-1:0]        lc_c, rc_c, len_ext;
  logic signed [DW-1:0] cmp_x, cmp_y;
  logic                 gt_c, take_c, full_c, load_out;
  logic [CW-1:0]        n_new;
  logic [CW-1:0]        half_n;

  assign lc_c    = {1'b0, root_r, 1'b1};
  assign rc_c    = lc_c + LW'(1);
  assign len_ext = LW'(len_r);
  assign full_c  = (count_r >= CW'(DEPTH));
  assign n_new   = full_c ? count_r : count_r + CW'(1);
  assign half_n  = n_new >> 1;

  // the one comparator, shared by the left and right child checks
  always_comb begin
    if (state_r == S_CMPR) begin
      cmp_x = rd_b_r;
      cmp_y = best_r;
    end else begin
      cmp_x = rd_a_r;
      cmp_y = vr_r;
    end
  end
  assign gt_c = cmp_x > cmp_y;

  assign load_out = !out_valid_r || !out_stall;

  always_comb begin
    ra_c = lc_c[AW-1:0];
    rb_c = rc_c[AW-1:0];
    case (state_r)
      S_FETCH:  ra_c = root_r;
      S_XFETCH: begin
        ra_c = '0;
        rb_c = AW'(i_r - CW'(1));
      end
      S_ERD, S_EOUT: ra_c = k_r;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    len_nxt       = len_r;
    root_nxt      = root_r;
    bigi_nxt      = bigi_r;
    moved_nxt     = moved_r;
    build_nxt     = build_r;
    k_nxt         = k_r;
    vr_nxt        = vr_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    out_drop_nxt  = out_drop_r;
    we_c          = 1'b0;
    wa_c          = root_r;
    wd_c          = vr_r;
    take_c        = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (!full_c) begin
            we_c      = 1'b1;
            wa_c      = count_r[AW-1:0];
            wd_c      = in_value;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt     = n_new;
            count_nxt = '0;
            k_nxt     = '0;
            if (n_new > CW'(1)) begin
              build_nxt = 1'b1;
              i_nxt     = half_n;
              root_nxt  = AW'(half_n - CW'(1));
              len_nxt   = n_new;
              state_nxt = S_FETCH;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end

      S_FETCH: state_nxt = S_ROOT;

      S_ROOT: begin
        vr_nxt    = rd_a_r;
        state_nxt = S_CMPL;
      end

      S_KIDS: state_nxt = S_CMPL;

      S_CMPL: begin
        take_c    = (lc_c < len_ext) && gt_c;
        best_nxt  = take_c ? rd_a_r : vr_r;
        bigi_nxt  = take_c ? lc_c[AW-1:0] : root_r;
        moved_nxt = take_c;
        state_nxt = S_CMPR;
      end

      S_CMPR: begin
        take_c = (rc_c < len_ext) && gt_c;
        we_c   = 1'b1;
        wa_c   = root_r;
        if (moved_r || take_c) begin
          // larger child moves up into the hole, hole moves down
          wd_c      = take_c ? rd_b_r : best_r;
          root_nxt  = take_c ? rc_c[AW-1:0] : bigi_r;
          state_nxt = S_KIDS;
        end else begin
          wd_c = vr_r;
          if (build_r) begin
            if (i_r > CW'(1)) begin
              i_nxt     = i_r - CW'(1);
              root_nxt  = AW'(i_r - CW'(2));
              state_nxt = S_FETCH;
            end else begin
              build_nxt = 1'b0;
              i_nxt     = n_r;
              state_nxt = S_XFETCH;
            end
          end else begin
            i_nxt = i_r - CW'(1);
            if (i_r > CW'(2)) begin
              state_nxt = S_XFETCH;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end

      S_XFETCH: state_nxt = S_XSWAP;

      S_XSWAP: begin
        // root goes to the end of the heap, old tail value sifts from the top
        we_c      = 1'b1;
        wa_c      = AW'(i_r - CW'(1));
        wd_c      = rd_a_r;
        vr_nxt    = rd_b_r;
        root_nxt  = '0;
        len_nxt   = i_r - CW'(1);
        state_nxt = S_KIDS;
      end

      S_ERD: state_nxt = S_EOUT;

      S_EOUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_a_r;
          out_drop_nxt  = ovf_r;
          out_end_nxt   = (CW'(k_r) + CW'(1) == n_r);
          if (CW'(k_r) + CW'(1) == n_r) begin
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    rd_a_r <= mem[ra_c];
    rd_b_r <= mem[rb_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    len_r       <= len_nxt;
    root_r      <= root_nxt;
    bigi_r      <= bigi_nxt;
    moved_r     <= moved_nxt;
    build_r     <= build_nxt;
    k_r         <= k_nxt;
    vr_r        <= vr_nxt;
    best_r      <= best_nxt;
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign in_stall         = (state_r != S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_dropped      = out_drop_r;

endmodule

// ----- tb/tb_heap_sorter.sv -----
// tb_heap_sorter: self-checking testbench for heap_sorter, loads sets of signed values
// and checks the ascending output of each set against a local sorting predictor
// depends on hs_pkg and heap_sorter
`timescale 1ns / 100ps

module tb_heap_sorter
  import hs_pkg::*;
();

  localparam int ITEM_TARGET = 330;
  localparam int STALL_LIMIT = 20000;
  localparam int IDLE_PCT    = 26;

  typedef enum {STYLE_WIDE, STYLE_NARROW, STYLE_EDGE, STYLE_SIGN} value_style_t;

  typedef struct {
    logic signed [DW-1:0] value;
    logic                 last;
    bit                   hold;  // wait for every pending result before driving
  } load_item_t;

  typedef struct {
    logic signed [DW-1:0] value;
    logic                 end_run;
    logic                 drop;
  } sorted_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] in_value;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_sorted_value;
  logic                 out_end_of_run;
  logic                 out_dropped;

  load_item_t     load_queue[$];
  sorted_result_t sorted_due[$];

  // predictor state
  logic signed [DW-1:0] set_store[DEPTH];
  int unsigned          set_count;
  bit                   set_overflow;

  bit in_taken;
  int queued_total;
  int values_loaded;
  int results_checked;
  int sets_sorted;
  int sets_dropping;
  int full_sets;
  int fail_cnt;
  int quiet_cycles;
  bit calm;

  heap_sorter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sorted_value(out_sorted_value),
    .out_end_of_run  (out_end_of_run),
    .out_dropped     (out_dropped)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // no idling on either side for a stretch in the middle of the run
  assign calm = (values_loaded >= 140) && (values_loaded < 230);

  // store one value and, on a last value, sort the set and queue its results
  function automatic void load_value(input logic signed [DW-1:0] v, input logic l);
    logic signed [DW-1:0] ordered[DEPTH];
    logic signed [DW-1:0] key;
    sorted_result_t       r;
    int                   j;
    if (set_count < DEPTH) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (l) begin
      for (int i = 0; i < set_count; i++) begin
        key = set_store[i];
        j = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      for (int k = 0; k < set_count; k++) begin
        r.value   = ordered[k];
        r.end_run = (k == set_count - 1);
        r.drop    = set_overflow;
        sorted_due.push_back(r);
      end
      sets_sorted++;
      if (set_overflow) sets_dropping++;
      if (set_count == DEPTH) full_sets++;
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endfunction

  function automatic logic signed [DW-1:0] pick_value(input value_style_t style);
    logic signed [DW-1:0] v;
    case (style)
      STYLE_NARROW: v = int'($urandom_range(8)) - 4;
      STYLE_EDGE: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 0;
          3: v = -1;
          4: v = 1;
          default: v = $urandom;
        endcase
      end
      STYLE_SIGN: v = {$urandom_range(1) == 1, 15'd0, 16'($urandom)};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void push_item(input logic signed [DW-1:0] v, input logic l,
                                    input bit hold);
    load_item_t it;
    it.value = v;
    it.last  = l;
    it.hold  = hold;
    load_queue.push_back(it);
    queued_total++;
  endfunction

  function automatic void queue_set(input int n, input value_style_t style, input bit hold);
    for (int i = 0; i < n; i++) push_item(pick_value(style), i == n - 1, hold && i == 0);
  endfunction

  // input driver: one transaction held until taken, random gaps between them
  always @(negedge clk) begin : drive_loads
    load_item_t it;
    bit         go;
    go = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      in_last  <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (load_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
        go = !(load_queue[0].hold && sorted_due.size() != 0);
      if (go) begin
        it = load_queue.pop_front();
        in_value <= it.value;
        in_last  <= it.last;
      end
      in_valid <= go;
    end
  end

  always @(negedge clk) begin : drive_stall
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // monitor: predicts on accepted loads, checks accepted results, watches for a hang
  always @(posedge clk) begin : watch_ports
    sorted_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_checked++;
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected result value %0d end_of_run %0b dropped %0b",
                   $time, out_sorted_value, out_end_of_run, out_dropped);
          fail_cnt++;
        end else begin
          want = sorted_due.pop_front();
          if (out_sorted_value !== want.value) begin
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, want.value, out_sorted_value);
            fail_cnt++;
          end
          if (out_end_of_run !== want.end_run) begin
            $display("%0t: end_of_run expected %0b actual %0b",
                     $time, want.end_run, out_end_of_run);
            fail_cnt++;
          end
          if (out_dropped !== want.drop) begin
            $display("%0t: dropped expected %0b actual %0b", $time, want.drop, out_dropped);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        values_loaded++;
        load_value(in_value, in_last);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sorted_due.size());
        $display("FAIL heap_sorter");
        $finish;
      end
    end
  end

  initial begin : run_test
    int           n;
    int           pick;
    value_style_t style;
    bit           hold;
    rst_n = 1'b0;

    // single value set
    push_item(7, 1'b1, 1'b0);
    // field extremes with repeats
    push_item(32'h7fff_ffff, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(0, 1'b0, 1'b0);
    push_item(-1, 1'b0, 1'b0);
    push_item(1, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'h7fff_ffff, 1'b1, 1'b0);
    // all equal
    for (int i = 0; i < 5; i++) push_item(42, i == 4, 1'b0);
    // reversed pair, then an already ordered set
    push_item(5, 1'b0, 1'b0);
    push_item(-5, 1'b1, 1'b0);
    push_item(-3, 1'b0, 1'b0);
    push_item(0, 1'b0, 1'b0);
    push_item(2, 1'b0, 1'b0);
    push_item(9, 1'b1, 1'b0);

    // store overrun, last value discarded too; wait for the directed results first
    queue_set(DEPTH + 2, STYLE_WIDE, 1'b1);
    // exactly full, no discard
    queue_set(DEPTH, STYLE_SIGN, 1'b0);

    while (queued_total < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 6) n = DEPTH;
      else if (pick < 12) n = DEPTH + 1 + $urandom_range(7);
      else n = 1 + $urandom_range(11);
      if (n > ITEM_TARGET - queued_total) n = ITEM_TARGET - queued_total;
      style = value_style_t'($urandom_range(3));
      hold  = ($urandom_range(9) == 0);
      queue_set(n, style, hold);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (load_queue.size() != 0 || in_valid) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d values in %0d sets loaded (%0d full, %0d overrunning the store)",
             values_loaded, sets_sorted, full_sets, sets_dropping);
    $display("%0d sorted results checked under random gaps and output stalls",
             results_checked);
    if (fail_cnt == 0) begin
      $display("PASS heap_sorter");
    end else begin
      $display("FAIL heap_sorter");
    end
    $finish;
  end

endmodule
